FILE: rtl/clhd_pkg.sv
// ----------------------------------------------------------------------------
// clhd_pkg
// Shared types and constants of the Content-Length header deframer.
// ----------------------------------------------------------------------------
package clhd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    // Characters the parser looks for.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Length of the key "Content-Length" and the saturation limit.
    localparam logic [3:0]  KEY_LEN = 4'd14;
    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

    // Where the current header line is: in the key, skipping spaces after
    // the colon, or in the value.
    typedef enum logic [2:0] {
        PH_KEY   = 3'b001,
        PH_SPACE = 3'b010,
        PH_VALUE = 3'b100
    } t_phase;

    // Lowercase letters of the key, one per position.
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ASCII uppercase to lowercase; other bytes pass unchanged.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z") begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

FILE: rtl/clhd_input_stage.sv
// ----------------------------------------------------------------------------
// clhd_input_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module clhd_input_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_stall,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import clhd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic       accept;

    // The register can load whenever it is empty or is being emptied.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: rtl/clhd_frame_core.sv
// ----------------------------------------------------------------------------
// clhd_frame_core
// Header line parser, length accumulator, body counter and result register.
// ----------------------------------------------------------------------------
module clhd_frame_core #(
    parameter int LINE_BUFFER = 80,
    parameter int MAX_DIGITS  = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    output logic        o_take,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [30:0] o_body_length,
    output logic        o_last
);
    import clhd_pkg::*;

    localparam int LINE_LIMIT = LINE_BUFFER - 2;
    localparam int LBW        = $clog2(LINE_BUFFER - 1);
    localparam int DCW        = $clog2(MAX_DIGITS + 2);

    typedef struct packed {
        logic [LBW-1:0] line_bytes;
        t_phase         phase;
        logic [3:0]     match_pos;
        logic           mismatch;
        logic           nul_seen;
        logic [DCW-1:0] digit_count;
        logic           value_bad;
    } t_line;

    typedef struct packed {
        t_line line;
        logic  add_digit;
    } t_step;

    localparam t_line LINE_CLEAR = '{
        line_bytes:  '0,
        phase:       PH_KEY,
        match_pos:   4'd0,
        mismatch:    1'b0,
        nul_seen:    1'b0,
        digit_count: '0,
        value_bad:   1'b0
    };

    function automatic logic key_ok(input t_line s);
        return !s.mismatch && (s.match_pos == KEY_LEN);
    endfunction

    // One content byte of a header line.
    function automatic t_step content_step(input t_line s, input logic [7:0] b);
        t_step r;
        r.line      = s;
        r.add_digit = 1'b0;
        if (s.line_bytes < LBW'(LINE_LIMIT)) begin
            r.line.line_bytes = s.line_bytes + LBW'(1);
            if (!s.nul_seen) begin
                if (b == CHAR_NUL) begin
                    r.line.nul_seen = 1'b1;
                end else if (s.phase == PH_KEY) begin
                    if (b == CHAR_COLON) begin
                        r.line.phase = PH_SPACE;
                    end else if (s.match_pos < KEY_LEN &&
                                 to_lower(b) == key_char(s.match_pos)) begin
                        r.line.match_pos = s.match_pos + 4'd1;
                    end else begin
                        r.line.mismatch = 1'b1;
                    end
                end else if (!(s.phase == PH_SPACE && b == CHAR_SPACE)) begin
                    r.line.phase = PH_VALUE;
                    if (key_ok(s)) begin
                        if (s.digit_count <= DCW'(MAX_DIGITS)) begin
                            r.line.digit_count = s.digit_count + DCW'(1);
                        end
                        if (b < CHAR_ZERO || b > CHAR_NINE) begin
                            r.line.value_bad = 1'b1;
                        end else begin
                            r.add_digit = 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // State registers.
    t_line       r_line,      n_line;
    logic        r_in_body,   n_in_body;
    logic        r_cr,        n_cr;
    logic [30:0] r_acc,       n_acc;
    logic [30:0] r_remaining, n_remaining;

    // Result register.
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind,      n_kind;
    logic [7:0]  r_data,      n_data;
    logic [30:0] r_len,       n_len;
    logic        r_last,      n_last;

    logic        take;
    t_step       step_cr;
    t_step       step_b;
    logic        add_digit;
    logic [34:0] acc_wide;

    // An item is processed only when the result register is free or leaving.
    assign take   = i_valid && (!r_out_valid || !i_stall);
    assign o_take = take;

    assign step_cr  = content_step(r_line, CHAR_CR);
    assign step_b   = content_step(r_cr ? step_cr.line : r_line, i_byte);
    assign acc_wide = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                    + {27'd0, i_byte - CHAR_ZERO};

    always_comb begin
        n_line      = r_line;
        n_in_body   = r_in_body;
        n_cr        = r_cr;
        n_acc       = r_acc;
        n_remaining = r_remaining;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_data      = r_data;
        n_len       = r_len;
        n_last      = r_last;
        add_digit   = 1'b0;

        if (take) begin
            if (r_in_body) begin
                n_out_valid = 1'b1;
                n_kind      = KIND_BODY;
                n_data      = i_byte;
                n_len       = 31'd0;
                n_last      = (r_remaining == 31'd1);
                n_remaining = r_remaining - 31'd1;
                if (r_remaining == 31'd1) begin
                    n_line    = LINE_CLEAR;
                    n_in_body = 1'b0;
                    n_cr      = 1'b0;
                    n_acc     = 31'd0;
                end
            end else if (r_cr && i_byte == CHAR_LF) begin
                // End of line.
                n_cr   = 1'b0;
                n_line = LINE_CLEAR;
                if (r_line.line_bytes == '0) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_HEADER;
                    n_data      = 8'd0;
                    n_len       = r_acc;
                    n_last      = (r_acc == 31'd0);
                    n_acc       = 31'd0;
                    n_in_body   = (r_acc != 31'd0);
                    n_remaining = r_acc;
                end else if (key_ok(r_line) &&
                             (r_line.phase == PH_KEY ||
                              r_line.digit_count > DCW'(MAX_DIGITS) ||
                              r_line.value_bad)) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_BAD;
                    n_data      = 8'd0;
                    n_len       = 31'd0;
                    n_last      = 1'b0;
                    n_acc       = 31'd0;
                    n_remaining = 31'd0;
                end
            end else if (r_cr) begin
                // The held CR was content after all.
                if (i_byte == CHAR_CR) begin
                    n_line = step_cr.line;
                end else begin
                    n_cr      = 1'b0;
                    n_line    = step_b.line;
                    add_digit = step_b.add_digit;
                end
            end else if (i_byte == CHAR_CR) begin
                n_cr = 1'b1;
            end else begin
                n_line    = step_b.line;
                add_digit = step_b.add_digit;
            end

            if (add_digit) begin
                n_acc = (acc_wide > {4'd0, LEN_MAX}) ? LEN_MAX : acc_wide[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= LINE_CLEAR;
            r_in_body   <= 1'b0;
            r_cr        <= 1'b0;
            r_acc       <= 31'd0;
            r_remaining <= 31'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_line      <= n_line;
            r_in_body   <= n_in_body;
            r_cr        <= n_cr;
            r_acc       <= n_acc;
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_body_length = r_len;
    assign o_last        = r_last;

endmodule

FILE: rtl/content_length_header_deframer.sv
// ----------------------------------------------------------------------------
// content_length_header_deframer
// Splits a byte stream into CRLF header lines, reads Content-Length and
// passes the following body bytes through.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall, i_in_byte) carries one received byte
// per word. The output channel (o_valid, i_stall and the result fields)
// carries at most one result per input word: a header-complete word with
// the parsed length, a body byte, or a bad-length-header word.
// A byte is registered in the input register on acceptance and is parsed
// once the result register is free or leaving, where its result is written
// to the output register that drives the output channel.
// One byte is taken every cycle while the receiver does not stall; the rate
// is set by the combinational line parser between the two registers.
// When the receiver stalls with a result waiting, the parser holds the next
// byte in the input register and o_stall rises only once that register is
// also full; a byte that yields no result still waits behind the held one.
// The synchronous, active-low reset empties both registers and returns the
// parser to the start of a header with the running length cleared.
// ----------------------------------------------------------------------------
module content_length_header_deframer #(
    parameter int LINE_BUFFER = 80,
    parameter int MAX_DIGITS  = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [30:0] o_body_length,
    output logic        o_last
);
    import clhd_pkg::*;

    // Byte held between the input register and the parser.
    logic       held_valid;
    logic [7:0] held_byte;
    logic       parser_take;

    clhd_input_stage u_input (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .o_stall   (o_stall),
        .i_take    (parser_take),
        .o_valid   (held_valid),
        .o_byte    (held_byte)
    );

    // The core parses a held byte whenever its result register can take a
    // new word, and drives the output channel straight from that register.
    clhd_frame_core #(
        .LINE_BUFFER (LINE_BUFFER),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (held_valid),
        .i_byte        (held_byte),
        .o_take        (parser_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_body_length (o_body_length),
        .o_last        (o_last)
    );

endmodule
